// ===== src/tlsct_pkg.sv =====
// Package for the three-level sparse code table.
// Holds the transfer payload types, operation codes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package tlsct_pkg;

    localparam int CODE_W   = 24;
    localparam int HANDLE_W = 32;
    localparam int BYTE_W   = 8;
    localparam int DIR_DEPTH = 256;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [CODE_W-1:0]   code;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] value;
        logic                status;
    } t_rsp;

    typedef enum logic [1:0] {
        RSP_ZERO,
        RSP_LOOKUP,
        RSP_DELETE,
        RSP_NOSPACE
    } t_rsp_sel;

    typedef struct packed {
        logic     load;
        logic     dir_alloc;
        logic     mid_rd;
        logic     mid_alloc;
        logic     mclr_wr;
        logic     lclr_wr;
        logic     leaf_rd;
        logic     leaf_wr_handle;
        logic     leaf_wr_zero;
        logic     rsp_load;
        t_rsp_sel rsp_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       dir_vld;
        logic       mid_vld;
        logic       mid_room;
        logic       leaf_room;
        logic       sweep_last;
    } t_sts;

    function automatic logic [BYTE_W-1:0] grp_of(input logic [CODE_W-1:0] code);
        grp_of = code[23:16];
    endfunction

    function automatic logic [BYTE_W-1:0] maj_of(input logic [CODE_W-1:0] code);
        maj_of = code[15:8];
    endfunction

    function automatic logic [BYTE_W-1:0] min_of(input logic [CODE_W-1:0] code);
        min_of = code[7:0];
    endfunction

endpackage

// ===== src/tlsct_ctrl.sv =====
// Controller for the three-level sparse code table.
// Walks directory, middle and leaf levels and sequences block clear sweeps.
// Depends on tlsct_pkg.
`timescale 1ns / 1ps

module tlsct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  tlsct_pkg::t_sts i_sts,
    output tlsct_pkg::t_cmd o_cmd,
    output logic            busy,
    output logic            o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR,
        S_MCLR,
        S_MID,
        S_LALLOC,
        S_LCLR,
        S_WR,
        S_LEAF
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsp_sel = tlsct_pkg::RSP_ZERO;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIR;
                end
            end
            S_DIR: begin
                if (i_sts.op == tlsct_pkg::OP_LOOKUP || i_sts.op == tlsct_pkg::OP_DELETE) begin
                    if (i_sts.dir_vld) begin
                        o_cmd.mid_rd = 1'b1;
                        n_state      = S_MID;
                    end else begin
                        o_cmd.rsp_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.op == tlsct_pkg::OP_ADD) begin
                    if (i_sts.dir_vld) begin
                        o_cmd.mid_rd = 1'b1;
                        n_state      = S_MID;
                    end else if (i_sts.mid_room) begin
                        o_cmd.dir_alloc = 1'b1;
                        n_state         = S_MCLR;
                    end else begin
                        o_cmd.rsp_load = 1'b1;
                        o_cmd.rsp_sel  = tlsct_pkg::RSP_NOSPACE;
                        n_state        = S_IDLE;
                    end
                end else begin
                    // unused op: empty result
                    o_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MCLR: begin
                o_cmd.mclr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_LALLOC;
                end
            end
            S_MID: begin
                if (i_sts.mid_vld) begin
                    o_cmd.leaf_rd = 1'b1;
                    n_state = (i_sts.op == tlsct_pkg::OP_ADD) ? S_WR : S_LEAF;
                end else if (i_sts.op == tlsct_pkg::OP_ADD) begin
                    n_state = S_LALLOC;
                end else begin
                    o_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LALLOC: begin
                if (i_sts.leaf_room) begin
                    o_cmd.mid_alloc = 1'b1;
                    n_state         = S_LCLR;
                end else begin
                    o_cmd.rsp_load = 1'b1;
                    o_cmd.rsp_sel  = tlsct_pkg::RSP_NOSPACE;
                    n_state        = S_IDLE;
                end
            end
            S_LCLR: begin
                o_cmd.lclr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.leaf_wr_handle = 1'b1;
                o_cmd.rsp_load       = 1'b1;
                n_state              = S_IDLE;
            end
            S_LEAF: begin
                o_cmd.rsp_load = 1'b1;
                if (i_sts.op == tlsct_pkg::OP_DELETE) begin
                    o_cmd.leaf_wr_zero = 1'b1;
                    o_cmd.rsp_sel      = tlsct_pkg::RSP_DELETE;
                end else begin
                    o_cmd.rsp_sel = tlsct_pkg::RSP_LOOKUP;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.rsp_load;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== src/tlsct_dp.sv =====
// Datapath for the three-level sparse code table.
// Directory, middle and leaf memories, pool counters, sweep counter and
// result register. Depends on tlsct_pkg.
`timescale 1ns / 1ps

module tlsct_dp #(
    parameter int MIDDLE_BLOCKS = 16,
    parameter int LEAF_BLOCKS   = 64,
    parameter int HANDLE_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlsct_pkg::t_req i_req,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  tlsct_pkg::t_cmd i_cmd,
    output tlsct_pkg::t_sts o_sts,
    output tlsct_pkg::t_rsp o_rsp
);

    localparam int BW  = tlsct_pkg::BYTE_W;
    localparam int MW  = (MIDDLE_BLOCKS > 1) ? $clog2(MIDDLE_BLOCKS) : 1;
    localparam int MCW = $clog2(MIDDLE_BLOCKS + 1);
    localparam int LW  = (LEAF_BLOCKS > 1) ? $clog2(LEAF_BLOCKS) : 1;
    localparam int LCW = $clog2(LEAF_BLOCKS + 1);
    localparam int SB  = (HANDLE_BITS < tlsct_pkg::HANDLE_W) ? HANDLE_BITS
                                                               : tlsct_pkg::HANDLE_W;

    typedef struct packed {
        logic          vld;
        logic [LW-1:0] blk;
    } t_link;

    logic [MW-1:0] m_dir  [0:tlsct_pkg::DIR_DEPTH-1];
    t_link         m_mid  [0:MIDDLE_BLOCKS*tlsct_pkg::DIR_DEPTH-1];
    logic [SB-1:0] m_leaf [0:LEAF_BLOCKS*tlsct_pkg::DIR_DEPTH-1];

    tlsct_pkg::t_req r_req;
    tlsct_pkg::t_rsp r_rsp;
    tlsct_pkg::t_rsp n_rsp;
    logic                          r_rel;
    logic [tlsct_pkg::DIR_DEPTH-1:0] r_dir_vld;
    logic                          r_dir_hit;
    logic [MW-1:0]                 r_dir_q;
    t_link                         r_mid_q;
    logic [SB-1:0]                 r_leaf_q;
    logic [MW-1:0]                 r_mid_blk;
    logic [LW-1:0]                 r_leaf_blk;
    logic [MCW-1:0]                r_mid_free;
    logic [LCW-1:0]                r_leaf_free;
    logic [BW-1:0]                 r_sweep;

    logic [BW-1:0]    req_grp, req_maj, req_min;
    logic             mid_we, leaf_we, leaf_hit;
    logic [MW+BW-1:0] mid_wa;
    t_link            mid_wd;
    logic [LW+BW-1:0] leaf_wa;
    logic [SB-1:0]    leaf_wd;

    assign req_grp = tlsct_pkg::grp_of(r_req.code);
    assign req_maj = tlsct_pkg::maj_of(r_req.code);
    assign req_min = tlsct_pkg::min_of(r_req.code);

    // directory: index in memory, valid bits in flops
    always_ff @(posedge i_clk) begin
        if (i_cmd.dir_alloc) begin
            m_dir[req_grp] <= r_mid_free[MW-1:0];
        end
        if (i_cmd.load) begin
            r_dir_q <= m_dir[tlsct_pkg::grp_of(i_req.code)];
        end
    end

    assign mid_we = i_cmd.mclr_wr | i_cmd.mid_alloc;
    assign mid_wa = i_cmd.mclr_wr ? {r_mid_blk, r_sweep} : {r_mid_blk, req_maj};
    always_comb begin
        mid_wd     = '0;
        mid_wd.vld = ~i_cmd.mclr_wr;
        mid_wd.blk = i_cmd.mclr_wr ? '0 : r_leaf_free[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mid_we) begin
            m_mid[mid_wa] <= mid_wd;
        end
        if (i_cmd.mid_rd) begin
            r_mid_q <= m_mid[{r_dir_q, req_maj}];
        end
    end

    assign leaf_we = i_cmd.lclr_wr | i_cmd.leaf_wr_handle | i_cmd.leaf_wr_zero;
    assign leaf_wa = i_cmd.lclr_wr ? {r_leaf_blk, r_sweep} : {r_leaf_blk, req_min};
    assign leaf_wd = i_cmd.leaf_wr_handle ? r_req.handle[SB-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            m_leaf[leaf_wa] <= leaf_wd;
        end
        if (i_cmd.leaf_rd) begin
            r_leaf_q <= m_leaf[{r_mid_q.blk, req_min}];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.dir_alloc) begin
            r_mid_blk <= r_mid_free[MW-1:0];
        end else if (i_cmd.mid_rd) begin
            r_mid_blk <= r_dir_q;
        end
        if (i_cmd.mid_alloc) begin
            r_leaf_blk <= r_leaf_free[LW-1:0];
        end else if (i_cmd.leaf_rd) begin
            r_leaf_blk <= r_mid_q.blk;
        end
        if (i_cmd.load) begin
            r_dir_hit <= r_dir_vld[tlsct_pkg::grp_of(i_req.code)];
        end
    end

    assign leaf_hit = |r_leaf_q;

    always_comb begin
        n_rsp = '0;
        case (i_cmd.rsp_sel)
            tlsct_pkg::RSP_LOOKUP: begin
                n_rsp.hit   = leaf_hit;
                n_rsp.value = tlsct_pkg::HANDLE_W'(r_leaf_q);
            end
            tlsct_pkg::RSP_DELETE: begin
                n_rsp.hit   = leaf_hit;
                n_rsp.value = r_rel ? tlsct_pkg::HANDLE_W'(r_leaf_q) : '0;
            end
            tlsct_pkg::RSP_NOSPACE: begin
                n_rsp.status = 1'b1;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_load) begin
            r_rsp <= n_rsp;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel       <= 1'b0;
            r_dir_vld   <= '0;
            r_mid_free  <= '0;
            r_leaf_free <= '0;
            r_sweep     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rel <= i_cfg_wdata;
            end
            if (i_cmd.dir_alloc) begin
                r_dir_vld[req_grp] <= 1'b1;
                r_mid_free         <= r_mid_free + MCW'(1);
            end
            if (i_cmd.mid_alloc) begin
                r_leaf_free <= r_leaf_free + LCW'(1);
            end
            // wraps back to zero at the end of each sweep
            if (i_cmd.mclr_wr || i_cmd.lclr_wr) begin
                r_sweep <= r_sweep + BW'(1);
            end
        end
    end

    assign o_sts.op         = r_req.op;
    assign o_sts.dir_vld    = r_dir_hit;
    assign o_sts.mid_vld    = r_mid_q.vld;
    assign o_sts.mid_room   = (r_mid_free < MCW'(MIDDLE_BLOCKS));
    assign o_sts.leaf_room  = (r_leaf_free < LCW'(LEAF_BLOCKS));
    assign o_sts.sweep_last = &r_sweep;

    assign o_rsp = r_rsp;

endmodule

// ===== src/three_level_sparse_code_table.sv =====
// Top level of the three-level sparse code table.
// Instantiates tlsct_ctrl and tlsct_dp; depends on tlsct_pkg.
//
// Usage:
//   Request: drive i_req (op, code, handle) with start high; the transfer
//   happens at a rising edge where busy is low. busy stays high until the
//   result has been produced.
//   Result: o_rsp (hit, value, status) is valid for exactly one cycle while
//   o_valid is high. The receiver cannot stall; it must take it then.
//   Config: i_cfg_we with i_cfg_wdata writes release_enable; write only
//   while busy is low.
// Sequencing:
//   Lookup, delete and add into existing blocks go through three dependent
//   registered reads (directory, middle, leaf); busy holds off a new request
//   until the current one is done. A miss at the directory or middle level
//   returns without reading the lower levels. A new leaf or middle block is
//   cleared before use: each block is swept one entry per cycle to clear it.
// Reset: synchronous, active low. All directory entries become invalid and
// both block pools become empty; memory contents need no clearing pass.
`timescale 1ns / 1ps

module three_level_sparse_code_table #(
    parameter int MIDDLE_BLOCKS = 16,
    parameter int LEAF_BLOCKS   = 64,
    parameter int HANDLE_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  tlsct_pkg::t_req i_req,
    output logic            busy,
    output logic            o_valid,
    output tlsct_pkg::t_rsp o_rsp,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);

    tlsct_pkg::t_cmd cmd;
    tlsct_pkg::t_sts sts;

    tlsct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    tlsct_dp #(
        .MIDDLE_BLOCKS (MIDDLE_BLOCKS),
        .LEAF_BLOCKS   (LEAF_BLOCKS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule
